FILE: hw/rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and register indexes of the wildcard byte pattern search.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned LenW      = 5;
  localparam int unsigned MaskW     = 16;

  typedef logic [CfgIndexW-1:0] cfg_index_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_PATTERN_LOW  = 3'd0,
    CFG_PATTERN_HIGH = 3'd1,
    CFG_WILDCARD     = 3'd2,
    CFG_LENGTH       = 3'd3,
    CFG_REGION_BASE  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] match_address;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
  } cell_lane_t;

  typedef struct packed {
    logic [7:0] expected;
    logic       care;
    logic       in_use;
  } cell_ref_t;

endpackage

FILE: hw/rtl/wbps_stream_if.sv
// ----------------------------------------------------------------------------
// wbps_stream_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface wbps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/wbps_cell.sv
// ----------------------------------------------------------------------------
// wbps_cell
// One window position: holds a byte and its region-valid flag, passes them
// on to the next cell per request and compares the incoming byte.
// ----------------------------------------------------------------------------
module wbps_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wbps_pkg::cell_ctrl_t ctrl_i,
  input  wbps_pkg::cell_lane_t lane_i,
  input  wbps_pkg::cell_ref_t  ref_i,
  output wbps_pkg::cell_lane_t lane_o,
  output logic                hit_o
);
  import wbps_pkg::*;

  logic [7:0] data_q;
  logic       valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= lane_i.valid && !ctrl_i.clear;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      data_q <= lane_i.data;
    end
  end

  assign lane_o.data  = data_q;
  assign lane_o.valid = valid_q;

  assign hit_o = !ref_i.in_use ||
                 (lane_i.valid && (!ref_i.care || (lane_i.data == ref_i.expected)));

endmodule

FILE: hw/rtl/wildcard_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search
// Scans a region byte by byte for a masked pattern and reports the first
// match address, or not found at the region's last byte.
// ----------------------------------------------------------------------------
//  channel | dir | payload                        | request when
//  req_i   | in  | data_byte, last_byte           | valid && ready
//  res_o   | out | found, match_address           | valid && ready
//  cfg     | in  | cfg_we_i, cfg_index_i, data    | cfg_we_i
//
//  One byte per cycle while req_i.ready is high; the new byte and the
//  MAX_PATTERN cells are compared in parallel in the cycle it is taken,
//  and the result is written into the output register at that cycle's end.
//  req_i.ready drops only while a result waits in the output register and
//  res_o.ready is low.
//  Reset clears the cell valid flags, byte count, given flag and output valid.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  wbps_pkg::cfg_index_t              cfg_index_i,
  input  logic [wbps_pkg::CfgDataW-1:0]     cfg_data_i,
  wbps_stream_if.sink                       req_i,
  wbps_stream_if.source                     res_o
);
  import wbps_pkg::*;

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PATTERN);

  // configuration
  logic [63:0]      pat_low_q;
  logic [63:0]      pat_high_q;
  logic [MaskW-1:0] mask_q;
  logic [LenW-1:0]  len_q;
  logic [AddrW-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      mask_q     <= '0;
      len_q      <= LenW'(1);
      base_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PATTERN_LOW:  pat_low_q  <= cfg_data_i;
        CFG_PATTERN_HIGH: pat_high_q <= cfg_data_i;
        CFG_WILDCARD:     mask_q     <= cfg_data_i[MaskW-1:0];
        CFG_LENGTH:       len_q      <= cfg_data_i[LenW-1:0];
        CFG_REGION_BASE:  base_q     <= cfg_data_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  logic [LenW-1:0]  n_act;
  logic [15:0][7:0] pat_bytes;

  always_comb begin
    n_act = len_q;
    if (n_act == '0) begin
      n_act = LenW'(1);
    end
    if (n_act > MaxLen) begin
      n_act = MaxLen;
    end
  end

  assign pat_bytes = {pat_high_q, pat_low_q};

  // handshake
  logic req_fire;
  logic out_valid_q;

  assign req_i.ready = !out_valid_q || res_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  // cell chain
  cell_ctrl_t                   ctrl;
  cell_lane_t [MAX_PATTERN:0]   lane;
  logic       [MAX_PATTERN-1:0] hit;
  logic       [MAX_PATTERN-1:0] cell_valid;

  assign ctrl.shift    = req_fire;
  assign ctrl.clear    = req_i.payload.last_byte;
  assign lane[0].data  = req_i.payload.data_byte;
  assign lane[0].valid = 1'b1;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [LenW-1:0] pidx;
    cell_ref_t       cref;

    assign pidx          = n_act - LenW'(1) - LenW'(j);
    assign cref.in_use   = LenW'(j) < n_act;
    assign cref.expected = pat_bytes[pidx[3:0]];
    assign cref.care     = (pidx == '0) || !mask_q[pidx[3:0]];
    assign cell_valid[j] = lane[j+1].valid;

    wbps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .lane_i (lane[j]),
      .ref_i  (cref),
      .lane_o (lane[j+1]),
      .hit_o  (hit[j])
    );
  end

  // region tracking
  logic             match;
  logic             given_q, given_d;
  logic [AddrW-1:0] seen_q, seen_d, seen_new;
  logic [AddrW-1:0] offset;
  logic             has_result;

  assign match      = &hit;
  assign seen_new   = (&seen_q) ? seen_q : seen_q + AddrW'(1);
  assign offset     = seen_new - AddrW'(n_act);
  assign has_result = req_fire && !given_q && (match || req_i.payload.last_byte);

  always_comb begin
    given_d = given_q;
    seen_d  = seen_q;
    if (req_fire) begin
      if (req_i.payload.last_byte) begin
        given_d = 1'b0;
        seen_d  = '0;
      end else begin
        given_d = given_q || match;
        seen_d  = seen_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      given_q <= 1'b0;
      seen_q  <= '0;
    end else begin
      given_q <= given_d;
      seen_q  <= seen_d;
    end
  end

  // output register
  logic             found_q;
  logic [AddrW-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (has_result) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (has_result) begin
      found_q  <= match;
      offset_q <= offset;
    end
  end

  assign res_o.valid                 = out_valid_q;
  assign res_o.payload.found         = found_q;
  assign res_o.payload.match_address = found_q ? base_q + offset_q : '0;

  // checks
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req_i.payload.last_byte |=> cell_valid == '0 && !given_q && seen_q == '0)
    else $error("region state not cleared after last byte");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> out_valid_q)
    else $error("input stalled with empty output register");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.payload.found |-> res_o.payload.match_address == '0)
    else $error("not-found result carries an address");

  a_one_per_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    has_result && !req_i.payload.last_byte |=> given_q)
    else $error("region result not recorded");

endmodule
